FILE: src/sorted_id_set_insert_core_assert.svh
// assertion macros for the insert core rtl
`ifndef SORTED_ID_SET_INSERT_CORE_ASSERT_SVH
`define SORTED_ID_SET_INSERT_CORE_ASSERT_SVH

`ifndef NO_ASSERTIONS

// checked on every clock edge outside reset
`define SID_ASSERT(lbl, prop, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) prop) else $error(msg);

// checked on every clock edge, reset included
`define SID_ASSERT_ALWAYS(lbl, prop, msg) \
	lbl: assert property (@(posedge clk) prop) else $error(msg);

`else

`define SID_ASSERT(lbl, prop, msg)
`define SID_ASSERT_ALWAYS(lbl, prop, msg)

`endif

`endif

FILE: src/sid_pkg.sv
package sid_pkg;

	localparam int CAPACITY = 1024;
	localparam int ADDR_W   = $clog2(CAPACITY);
	localparam int CNT_W    = ADDR_W + 1;
	localparam int ID_W     = 30;
	localparam int DIG_W    = 4;

	localparam logic [DIG_W-1:0] DIGITS_RESET = 4'd8;
	localparam logic [DIG_W-1:0] MAX_DIGITS   = 4'd10;

	typedef enum logic [1:0] {
		ST_INSERTED   = 2'd0,
		ST_PRESENT    = 2'd1,
		ST_BAD_LENGTH = 2'd2,
		ST_FULL       = 2'd3
	} status_t;

	// powers of ten that fit the identifier width
	function automatic logic [ID_W-1:0] pow10(input logic [DIG_W-1:0] k);
		logic [ID_W-1:0] r;
		unique case (k)
			4'd0: r = 30'd1;
			4'd1: r = 30'd10;
			4'd2: r = 30'd100;
			4'd3: r = 30'd1000;
			4'd4: r = 30'd10000;
			4'd5: r = 30'd100000;
			4'd6: r = 30'd1000000;
			4'd7: r = 30'd10000000;
			4'd8: r = 30'd100000000;
			4'd9: r = 30'd1000000000;
			default: r = '0;
		endcase
		return r;
	endfunction

	// true when v has exactly d decimal digits (zero has none)
	function automatic logic digits_ok(input logic [ID_W-1:0] v, input logic [DIG_W-1:0] d);
		logic ok;
		if (d == '0) begin
			ok = (v == '0);
		end else if (d < MAX_DIGITS) begin
			ok = (v >= pow10(DIG_W'(d - 4'd1))) && (v < pow10(d));
		end else if (d == MAX_DIGITS) begin
			ok = (v >= pow10(DIG_W'(MAX_DIGITS - 4'd1)));
		end else begin
			ok = 1'b0;
		end
		return ok;
	endfunction

endpackage

FILE: src/sorted_id_set_insert_core.sv
// channel   direction  handshake             payload
// in        input      in_valid / in_ready   card_id
// out       output     out_valid / out_ready status, entries_used
// cfg       input      cfg_valid / cfg_ready cfg_data (required digit count)
//
// a transaction checks the digit count, then for a good count searches with p probes
// (at most 11) to a hit or the end of the window; then a full table ends it or an
// insert moves m entries up and writes the key, one table move per cycle through
// the single write port of the table ram
// in_ready is high only while the sequencer is idle and rises with out_valid; the
// result register lets the next transaction in while a result still waits for
// out_ready, and the sequencer holds its next result until that register is free
// the table ram has no reset and no clearing pass; only entries below the count
// are ever used, and arst_n clears the count, the sequencer and out_valid
// cfg_ready is always high; a write takes effect at once, so the user must write
// it only between transactions, which the block itself does not enforce
`include "sorted_id_set_insert_core_assert.svh"

module sorted_id_set_insert_core (
	input  logic                              clk,
	input  logic                              arst_n,
	input  logic                              in_valid,
	output logic                              in_ready,
	input  logic [sid_pkg::ID_W-1:0]          card_id,
	output logic                              out_valid,
	input  logic                              out_ready,
	output sid_pkg::status_t                  status,
	output logic [sid_pkg::CNT_W-1:0]         entries_used,
	input  logic                              cfg_valid,
	output logic                              cfg_ready,
	input  logic [sid_pkg::DIG_W-1:0]         cfg_data
);

	import sid_pkg::*;

	// sequencer states, one-hot
	typedef enum logic [6:0] {
		S_IDLE     = 7'b0000001,
		S_CHECK    = 7'b0000010,
		S_SRCH_ADR = 7'b0000100,
		S_SRCH_CMP = 7'b0001000,
		S_SHIFT    = 7'b0010000,
		S_INSERT   = 7'b0100000,
		S_DONE     = 7'b1000000
	} state_t;

	state_t            state_q;
	logic [DIG_W-1:0]  req_digits_q;
	logic [CNT_W-1:0]  count_q;
	logic              out_valid_q;
	status_t           out_status_q;
	logic [CNT_W-1:0]  out_entries_q;

	// working registers of the current transaction
	logic [ID_W-1:0]   key_q;
	status_t           res_q;
	logic [CNT_W-1:0]  lo_q;
	logic [CNT_W-1:0]  hi_q;
	logic [CNT_W-1:0]  mid_q;
	logic [CNT_W-1:0]  idx_q;
	logic              wr_pend_q;
	logic [ADDR_W-1:0] wr_addr_q;

	logic [CNT_W:0]    mid_sum;
	logic [CNT_W-1:0]  mid;
	logic [CNT_W-1:0]  idx_dec;
	logic              ram_wr_en;
	logic [ADDR_W-1:0] ram_wr_addr;
	logic [ID_W-1:0]   ram_wr_data;
	logic [ADDR_W-1:0] ram_rd_addr;
	logic [ID_W-1:0]   ram_rd_data;
	logic              out_free;

	// midpoint of the open search window [lo, hi)
	assign mid_sum = {1'b0, lo_q} + {1'b0, hi_q};
	assign mid     = mid_sum[CNT_W:1];
	assign idx_dec = idx_q - CNT_W'(1);

	assign out_free = !out_valid_q || out_ready;

	// table port selection: search reads the midpoint, the shift reads one
	// entry below the cursor and writes the previous read one slot up; insert writes the key
	always_comb begin
		ram_rd_addr = '0;
		ram_wr_en   = 1'b0;
		ram_wr_addr = wr_addr_q;
		ram_wr_data = ram_rd_data;
		if (state_q == S_SRCH_ADR) begin
			ram_rd_addr = mid[ADDR_W-1:0];
		end else if (state_q == S_SHIFT) begin
			ram_rd_addr = idx_dec[ADDR_W-1:0];
			ram_wr_en   = wr_pend_q;
		end else if (state_q == S_INSERT) begin
			ram_wr_en   = 1'b1;
			ram_wr_addr = lo_q[ADDR_W-1:0];
			ram_wr_data = key_q;
		end
	end

	sid_ram #(
		.WIDTH(ID_W),
		.DEPTH(CAPACITY)
	) u_table (
		.clk    (clk),
		.wr_en  (ram_wr_en),
		.wr_addr(ram_wr_addr),
		.wr_data(ram_wr_data),
		.rd_addr(ram_rd_addr),
		.rd_data(ram_rd_data)
	);

	// control state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q      <= S_IDLE;
			req_digits_q <= DIGITS_RESET;
			count_q      <= '0;
			out_valid_q  <= 1'b0;
			wr_pend_q    <= 1'b0;
		end else begin
			if (cfg_valid) begin
				req_digits_q <= cfg_data;
			end
			// a new result replaces the one leaving in the same cycle
			if (state_q == S_DONE && out_free) begin
				out_valid_q <= 1'b1;
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end
			unique case (state_q)
				S_IDLE: begin
					if (in_valid) begin
						state_q <= S_CHECK;
					end
				end
				S_CHECK: begin
					if (digits_ok(key_q, req_digits_q)) begin
						state_q <= S_SRCH_ADR;
					end else begin
						state_q <= S_DONE;
					end
				end
				S_SRCH_ADR: begin
					if (lo_q < hi_q) begin
						state_q <= S_SRCH_CMP;
					end else if (count_q == CNT_W'(CAPACITY)) begin
						state_q <= S_DONE;
					end else begin
						state_q <= S_SHIFT;
					end
				end
				S_SRCH_CMP: begin
					if (ram_rd_data == key_q) begin
						state_q <= S_DONE;
					end else begin
						state_q <= S_SRCH_ADR;
					end
				end
				S_SHIFT: begin
					if (idx_q > lo_q) begin
						wr_pend_q <= 1'b1;
					end else begin
						wr_pend_q <= 1'b0;
						state_q   <= S_INSERT;
					end
				end
				S_INSERT: begin
					count_q <= count_q + CNT_W'(1);
					state_q <= S_DONE;
				end
				S_DONE: begin
					if (out_free) begin
						state_q <= S_IDLE;
					end
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end

	// datapath of the current transaction and the result register
	always_ff @(posedge clk) begin
		unique case (state_q)
			S_IDLE: begin
				if (in_valid) begin
					key_q <= card_id;
				end
			end
			S_CHECK: begin
				res_q <= ST_BAD_LENGTH;
				lo_q  <= '0;
				hi_q  <= count_q;
			end
			S_SRCH_ADR: begin
				mid_q <= mid;
				idx_q <= count_q;
				if (!(lo_q < hi_q)) begin
					if (count_q == CNT_W'(CAPACITY)) begin
						res_q <= ST_FULL;
					end else begin
						res_q <= ST_INSERTED;
					end
				end
			end
			S_SRCH_CMP: begin
				if (ram_rd_data == key_q) begin
					res_q <= ST_PRESENT;
				end else if (key_q > ram_rd_data) begin
					lo_q <= mid_q + CNT_W'(1);
				end else begin
					hi_q <= mid_q;
				end
			end
			S_SHIFT: begin
				if (idx_q > lo_q) begin
					wr_addr_q <= idx_q[ADDR_W-1:0];
					idx_q     <= idx_dec;
				end
			end
			S_INSERT: begin
			end
			S_DONE: begin
				if (out_free) begin
					out_status_q  <= res_q;
					out_entries_q <= count_q;
				end
			end
			default: begin
			end
		endcase
	end

	assign in_ready     = (state_q == S_IDLE);
	assign cfg_ready    = 1'b1;
	assign out_valid    = out_valid_q;
	assign status       = out_status_q;
	assign entries_used = out_entries_q;

	`SID_ASSERT(a_count_bound, count_q <= CNT_W'(CAPACITY), "entry count above capacity")
	`SID_ASSERT(a_insert_incr, (state_q == S_INSERT) |=> (count_q == $past(count_q) + CNT_W'(1)), "insert did not bump the count")
	`SID_ASSERT(a_window, (state_q == S_SRCH_ADR || state_q == S_SRCH_CMP) |-> (lo_q <= hi_q && hi_q <= count_q), "search window out of order")
	`SID_ASSERT(a_pend_shift, wr_pend_q |-> (state_q == S_SHIFT), "shift write pending outside shift")
	`SID_ASSERT(a_shift_addr, (state_q == S_SHIFT && wr_pend_q) |-> (ram_wr_addr != ram_rd_addr), "shift reads the slot it writes")
	`SID_ASSERT_ALWAYS(a_reset_clear, !arst_n |=> (!out_valid_q && state_q == S_IDLE), "reset left a result or a busy sequencer")

endmodule

FILE: src/sid_ram.sv
module sid_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 16
) (
	input  logic                     clk,
	input  logic                     wr_en,
	input  logic [$clog2(DEPTH)-1:0] wr_addr,
	input  logic [WIDTH-1:0]         wr_data,
	input  logic [$clog2(DEPTH)-1:0] rd_addr,
	output logic [WIDTH-1:0]         rd_data
);

	logic [WIDTH-1:0] mem_q [DEPTH];
	logic [WIDTH-1:0] rd_data_q;

	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem_q[wr_addr] <= wr_data;
		end
		rd_data_q <= mem_q[rd_addr];
	end

	assign rd_data = rd_data_q;

endmodule
